@@ hw/rtl/mmfn_pkg.sv @@
`timescale 1ns / 1ps

package mmfn_pkg;

    // feature table size and the derived address width
    localparam int MAX_FEATURES = 16;
    localparam int FEAT_AW      = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    // field widths
    localparam int MODE_W   = 2;
    localparam int IDX_W    = 4;
    localparam int VAL_W    = 24;
    localparam int FRAC_W   = 16;
    localparam int SCALED_W = FRAC_W + 1;
    localparam int DIFF_W   = VAL_W + 1;
    localparam int CNT_W    = (FRAC_W > 1) ? $clog2(FRAC_W) : 1;

    // stream widths, whole bytes
    localparam int S_TDATA_W = ((IDX_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SCALED_W + IDX_W + 7) / 8) * 8;

    // statistics reset values
    localparam logic signed [VAL_W-1:0] VAL_MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MOST_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [SCALED_W-1:0]     FRAC_ONE     = {1'b1, {FRAC_W{1'b0}}};

    // mode codes (code 3 is unused)
    localparam logic [MODE_W-1:0] MODE_COLLECT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORM    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SETUP,
        ST_CHECK,
        ST_DIV,
        ST_OUT
    } t_state;

    // handshake between sequencer and divider
    typedef struct packed {
        logic start;
    } t_div_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ hw/rtl/mmfn_div.sv @@
`timescale 1ns / 1ps

// radix-2 restoring divider, one quotient bit per cycle
// expects 0 < num < den, gives floor(num * 2^FRAC_W / den)
module mmfn_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mmfn_pkg::t_div_cmd              i_cmd,
    input  logic [mmfn_pkg::VAL_W-1:0]      i_num,
    input  logic [mmfn_pkg::VAL_W-1:0]      i_den,
    output mmfn_pkg::t_div_stat             o_stat,
    output logic [mmfn_pkg::FRAC_W-1:0]     o_quot
);

    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [mmfn_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [mmfn_pkg::VAL_W-1:0]       r_rem, n_rem;
    logic [mmfn_pkg::VAL_W-1:0]       r_den, n_den;
    logic [mmfn_pkg::FRAC_W-1:0]      r_quot, n_quot;

    logic [mmfn_pkg::VAL_W:0]         w_shift;
    logic [mmfn_pkg::VAL_W:0]         w_den_ext;
    logic [mmfn_pkg::VAL_W:0]         w_sub;
    logic                             w_ge;

    assign w_shift   = {r_rem, 1'b0};
    assign w_den_ext = {1'b0, r_den};
    assign w_sub     = w_shift - w_den_ext;
    assign w_ge      = (w_shift >= w_den_ext);

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_cmd.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_den  = i_den;
            n_quot = '0;
        end else if (r_busy) begin
            // remainder stays below den, so it fits back in VAL_W bits
            n_rem  = w_ge ? w_sub[mmfn_pkg::VAL_W-1:0] : w_shift[mmfn_pkg::VAL_W-1:0];
            n_quot = {r_quot[mmfn_pkg::FRAC_W-2:0], w_ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == mmfn_pkg::CNT_W'(mmfn_pkg::FRAC_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

@@ hw/rtl/min_max_feature_normalizer.sv @@
`timescale 1ns / 1ps

// channel  | direction | tdata (low bit up)                      | tuser
// ---------+-----------+-----------------------------------------+-----------------
// s (in)   | sink      | feature_index[3:0], sample_value[27:4]  | mode[1:0]
// m (out)  | source    | scaled_value[16:0], result_feature[20:17] | degenerate[0]
//
// collect and clear pass through accept (ST_IDLE) and table update (ST_LOAD) per transaction
// normalize runs load, setup and check, then the 16-step radix-2 divider unless the result
// is clamped or degenerate, then output; the input is not ready again until output is loaded
// i_rst_n (synchronous) loads every feature with max = most negative, min = most positive
// the output register holds one result; a stalled sink only blocks the next normalize
// at its last step, collect and clear keep flowing

module min_max_feature_normalizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [mmfn_pkg::S_TDATA_W-1:0]     i_s_tdata,   // feature_index, sample_value
    input  logic [mmfn_pkg::MODE_W-1:0]        i_s_tuser,   // mode
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [mmfn_pkg::M_TDATA_W-1:0]     o_m_tdata,   // scaled_value, result_feature
    output logic                               o_m_tuser    // degenerate
);

    localparam int VW = mmfn_pkg::VAL_W;
    localparam int DW = mmfn_pkg::DIFF_W;

    // sequencer state and captured transaction
    mmfn_pkg::t_state                  r_state, n_state;
    logic [mmfn_pkg::MODE_W-1:0]       r_mode, n_mode;
    logic [mmfn_pkg::IDX_W-1:0]        r_idx, n_idx;
    logic signed [VW-1:0]              r_val, n_val;

    // working registers of the normalize path
    logic signed [VW-1:0]              r_max, n_max;
    logic signed [VW-1:0]              r_min, n_min;
    logic signed [DW-1:0]              r_num, n_num;
    logic signed [DW-1:0]              r_den, n_den;
    logic [mmfn_pkg::SCALED_W-1:0]     r_res_scaled, n_res_scaled;
    logic                              r_res_degen, n_res_degen;

    // output register
    logic                              r_out_valid, n_out_valid;
    logic [mmfn_pkg::SCALED_W-1:0]     r_out_scaled, n_out_scaled;
    logic                              r_out_degen, n_out_degen;
    logic [mmfn_pkg::IDX_W-1:0]        r_out_feat, n_out_feat;

    // per-feature statistics, one flop row per feature
    logic signed [VW-1:0]              r_fmax [mmfn_pkg::MAX_FEATURES];
    logic signed [VW-1:0]              r_fmin [mmfn_pkg::MAX_FEATURES];

    logic [mmfn_pkg::FEAT_AW-1:0]      w_addr;
    logic                              w_idx_ok;
    logic signed [VW-1:0]              w_rd_max;
    logic signed [VW-1:0]              w_rd_min;
    logic                              w_st_we;
    logic signed [VW-1:0]              w_st_max;
    logic signed [VW-1:0]              w_st_min;

    mmfn_pkg::t_div_cmd                w_div_cmd;
    mmfn_pkg::t_div_stat               w_div_stat;
    logic [mmfn_pkg::FRAC_W-1:0]       w_div_quot;

    logic                              w_s_fire;

    // nothing is taken while reset is held
    assign o_s_tready = (r_state == mmfn_pkg::ST_IDLE) && i_rst_n;
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    assign w_addr   = mmfn_pkg::FEAT_AW'(r_idx);
    assign w_idx_ok = (32'(r_idx) < mmfn_pkg::MAX_FEATURES);
    assign w_rd_max = r_fmax[w_addr];
    assign w_rd_min = r_fmin[w_addr];

    mmfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_div_cmd),
        .i_num   (r_num[VW-1:0]),
        .i_den   (r_den[VW-1:0]),
        .o_stat  (w_div_stat),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_idx        = r_idx;
        n_val        = r_val;
        n_max        = r_max;
        n_min        = r_min;
        n_num        = r_num;
        n_den        = r_den;
        n_res_scaled = r_res_scaled;
        n_res_degen  = r_res_degen;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_scaled = r_out_scaled;
        n_out_degen  = r_out_degen;
        n_out_feat   = r_out_feat;
        w_st_we      = 1'b0;
        w_st_max     = w_rd_max;
        w_st_min     = w_rd_min;
        w_div_cmd.start = 1'b0;

        case (r_state)
            mmfn_pkg::ST_IDLE: begin
                if (w_s_fire) begin
                    n_mode  = i_s_tuser;
                    n_idx   = i_s_tdata[mmfn_pkg::IDX_W-1:0];
                    n_val   = i_s_tdata[mmfn_pkg::IDX_W +: VW];
                    n_state = mmfn_pkg::ST_LOAD;
                end
            end
            mmfn_pkg::ST_LOAD: begin
                case (r_mode)
                    mmfn_pkg::MODE_COLLECT: begin
                        // fold the sample into the running extremes
                        w_st_we  = w_idx_ok;
                        w_st_max = (r_val > w_rd_max) ? r_val : w_rd_max;
                        w_st_min = (r_val < w_rd_min) ? r_val : w_rd_min;
                        n_state  = mmfn_pkg::ST_IDLE;
                    end
                    mmfn_pkg::MODE_CLEAR: begin
                        w_st_we  = w_idx_ok;
                        w_st_max = mmfn_pkg::VAL_MOST_NEG;
                        w_st_min = mmfn_pkg::VAL_MOST_POS;
                        n_state  = mmfn_pkg::ST_IDLE;
                    end
                    mmfn_pkg::MODE_NORM: begin
                        // an out-of-range feature looks like one with no data
                        n_max   = w_idx_ok ? w_rd_max : mmfn_pkg::VAL_MOST_NEG;
                        n_min   = w_idx_ok ? w_rd_min : mmfn_pkg::VAL_MOST_POS;
                        n_state = mmfn_pkg::ST_SETUP;
                    end
                    default: begin
                        n_state = mmfn_pkg::ST_IDLE;
                    end
                endcase
            end
            mmfn_pkg::ST_SETUP: begin
                // exact differences in Q.8, one bit wider than the samples
                n_den   = DW'(r_max) - DW'(r_min);
                n_num   = DW'(r_val) - DW'(r_min);
                n_state = mmfn_pkg::ST_CHECK;
            end
            mmfn_pkg::ST_CHECK: begin
                if (r_den[DW-1] || (r_den == '0)) begin
                    // no data or zero range
                    n_res_scaled = '0;
                    n_res_degen  = 1'b1;
                    n_state      = mmfn_pkg::ST_OUT;
                end else if (r_num[DW-1] || (r_num == '0)) begin
                    // at or below min, saturate low
                    n_res_scaled = '0;
                    n_res_degen  = 1'b0;
                    n_state      = mmfn_pkg::ST_OUT;
                end else if (r_num >= r_den) begin
                    // at or above max, saturate high
                    n_res_scaled = mmfn_pkg::FRAC_ONE;
                    n_res_degen  = 1'b0;
                    n_state      = mmfn_pkg::ST_OUT;
                end else begin
                    w_div_cmd.start = 1'b1;
                    n_res_degen     = 1'b0;
                    n_state         = mmfn_pkg::ST_DIV;
                end
            end
            mmfn_pkg::ST_DIV: begin
                if (w_div_stat.done) begin
                    n_res_scaled = {1'b0, w_div_quot};
                    n_state      = mmfn_pkg::ST_OUT;
                end
            end
            mmfn_pkg::ST_OUT: begin
                // load once the output register is free or being drained
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_scaled = r_res_scaled;
                    n_out_degen  = r_res_degen;
                    n_out_feat   = r_idx;
                    n_state      = mmfn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mmfn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmfn_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mode       <= n_mode;
        r_idx        <= n_idx;
        r_val        <= n_val;
        r_max        <= n_max;
        r_min        <= n_min;
        r_num        <= n_num;
        r_den        <= n_den;
        r_res_scaled <= n_res_scaled;
        r_res_degen  <= n_res_degen;
        r_out_scaled <= n_out_scaled;
        r_out_degen  <= n_out_degen;
        r_out_feat   <= n_out_feat;
    end

    // statistics table: reset puts every feature back to the empty state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < mmfn_pkg::MAX_FEATURES; f++) begin
                r_fmax[f] <= mmfn_pkg::VAL_MOST_NEG;
                r_fmin[f] <= mmfn_pkg::VAL_MOST_POS;
            end
        end else if (w_st_we) begin
            r_fmax[w_addr] <= w_st_max;
            r_fmin[w_addr] <= w_st_min;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(mmfn_pkg::M_TDATA_W - mmfn_pkg::SCALED_W - mmfn_pkg::IDX_W){1'b0}},
                         r_out_feat, r_out_scaled};
    assign o_m_tuser  = r_out_degen;

endmodule

@@ tb/tb_min_max_feature_normalizer.sv @@
`timescale 1ns / 1ps

module tb_min_max_feature_normalizer;

    // tuser code that the block must ignore
    localparam logic [mmfn_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // one normalize result as it leaves the block
    typedef struct packed {
        logic [mmfn_pkg::SCALED_W-1:0] scaled;
        logic                          degen;
        logic [mmfn_pkg::IDX_W-1:0]    feat;
    } t_norm_result;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [mmfn_pkg::S_TDATA_W-1:0]  i_s_tdata  = '0;   // feature_index, sample_value
    logic [mmfn_pkg::MODE_W-1:0]     i_s_tuser  = mmfn_pkg::MODE_COLLECT;   // mode
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [mmfn_pkg::M_TDATA_W-1:0]  o_m_tdata;   // scaled_value, result_feature
    logic                            o_m_tuser;   // degenerate

    // shadow copy of the per-feature statistics
    logic signed [mmfn_pkg::VAL_W-1:0] feat_max [mmfn_pkg::MAX_FEATURES];
    logic signed [mmfn_pkg::VAL_W-1:0] feat_min [mmfn_pkg::MAX_FEATURES];

    // normalize results predicted but not yet seen on the master side
    t_norm_result pending_norm [$];
    t_norm_result want_result;

    int mismatch_count = 0;
    int src_idle_pct   = 0;   // chance per cycle that the sender holds off
    int sink_stall_pct = 0;   // chance per cycle that the receiver deasserts tready

    min_max_feature_normalizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // exact Q1.16 fraction of (value - min) / (max - min), clamped to 0..1
    function automatic t_norm_result norm_fraction(
            input logic [mmfn_pkg::IDX_W-1:0] idx,
            input logic signed [mmfn_pkg::VAL_W-1:0] value);
        t_norm_result r;
        longint       span;
        longint       offset;
        span   = longint'(feat_max[idx]) - longint'(feat_min[idx]);
        offset = longint'(value) - longint'(feat_min[idx]);
        r.feat = idx;
        r.degen = 1'b0;
        if (span <= 0) begin
            // no samples yet or all samples equal
            r.degen  = 1'b1;
            r.scaled = '0;
        end else if (offset <= 0) begin
            r.scaled = '0;
        end else if (offset >= span) begin
            r.scaled = mmfn_pkg::FRAC_ONE;
        end else begin
            r.scaled = mmfn_pkg::SCALED_W'((offset << mmfn_pkg::FRAC_W) / span);
        end
        return r;
    endfunction

    // apply one accepted transaction to the shadow statistics
    function automatic void track_transaction(
            input logic [mmfn_pkg::MODE_W-1:0] mode,
            input logic [mmfn_pkg::IDX_W-1:0] idx,
            input logic signed [mmfn_pkg::VAL_W-1:0] value);
        case (mode)
            mmfn_pkg::MODE_COLLECT: begin
                if (value > feat_max[idx]) feat_max[idx] = value;
                if (value < feat_min[idx]) feat_min[idx] = value;
            end
            mmfn_pkg::MODE_NORM: begin
                pending_norm = {pending_norm, norm_fraction(idx, value)};
            end
            mmfn_pkg::MODE_CLEAR: begin
                feat_max[idx] = mmfn_pkg::VAL_MOST_NEG;
                feat_min[idx] = mmfn_pkg::VAL_MOST_POS;
            end
            default: begin
            end
        endcase
    endfunction

    // value around base, kept inside the Q15.8 range
    function automatic logic signed [mmfn_pkg::VAL_W-1:0] near_value(input int base,
                                                                     input int spread);
        longint v;
        v = longint'(base) + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
        if (v < longint'(mmfn_pkg::VAL_MOST_NEG)) v = longint'(mmfn_pkg::VAL_MOST_NEG);
        if (v > longint'(mmfn_pkg::VAL_MOST_POS)) v = longint'(mmfn_pkg::VAL_MOST_POS);
        return v[mmfn_pkg::VAL_W-1:0];
    endfunction

    // drive one transaction on the slave side and wait for its acceptance
    task automatic send_item(input logic [mmfn_pkg::MODE_W-1:0] mode,
                             input logic [mmfn_pkg::IDX_W-1:0] idx,
                             input logic signed [mmfn_pkg::VAL_W-1:0] value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {{(mmfn_pkg::S_TDATA_W - mmfn_pkg::IDX_W - mmfn_pkg::VAL_W){1'b0}},
                       value, idx};
        do @(posedge i_clk); while (!o_s_tready);
        track_transaction(mode, idx, value);
    endtask

    // features with no samples answer degenerate
    task automatic test_empty_features();
        send_item(mmfn_pkg::MODE_NORM, 4'd0, '0);
        send_item(mmfn_pkg::MODE_NORM, 4'd15, mmfn_pkg::VAL_MOST_NEG);
    endtask

    // one sample gives max == min
    task automatic test_zero_range();
        send_item(mmfn_pkg::MODE_COLLECT, 4'd3, 24'sd100);
        send_item(mmfn_pkg::MODE_NORM, 4'd3, 24'sd100);
    endtask

    // widest possible range, values at both ends and the middle
    task automatic test_full_range_extremes();
        send_item(mmfn_pkg::MODE_COLLECT, 4'd3, mmfn_pkg::VAL_MOST_NEG);
        send_item(mmfn_pkg::MODE_COLLECT, 4'd3, mmfn_pkg::VAL_MOST_POS);
        send_item(mmfn_pkg::MODE_NORM, 4'd3, mmfn_pkg::VAL_MOST_NEG);
        send_item(mmfn_pkg::MODE_NORM, 4'd3, mmfn_pkg::VAL_MOST_POS);
        send_item(mmfn_pkg::MODE_NORM, 4'd3, '0);
        send_item(mmfn_pkg::MODE_NORM, 4'd3, mmfn_pkg::VAL_MOST_POS - 24'sd1);
    endtask

    // unused code leaves the table alone, clear empties the feature
    task automatic test_unused_mode_and_clear();
        send_item(MODE_UNUSED, 4'd3, mmfn_pkg::VAL_MOST_POS);
        send_item(mmfn_pkg::MODE_NORM, 4'd3, '0);
        send_item(mmfn_pkg::MODE_CLEAR, 4'd3, '0);
        send_item(mmfn_pkg::MODE_NORM, 4'd3, '0);
    endtask

    // values below min and above max saturate, clearing another feature leaves this one alone
    task automatic test_clamping();
        send_item(mmfn_pkg::MODE_COLLECT, 4'd15, -24'sd256);
        send_item(mmfn_pkg::MODE_COLLECT, 4'd15, 24'sd256);
        send_item(mmfn_pkg::MODE_NORM, 4'd15, -24'sd512);
        send_item(mmfn_pkg::MODE_NORM, 4'd15, 24'sd512);
        send_item(mmfn_pkg::MODE_NORM, 4'd15, '0);
        send_item(mmfn_pkg::MODE_NORM, 4'd15, 24'sd255);
        send_item(mmfn_pkg::MODE_CLEAR, 4'd0, '0);
        send_item(mmfn_pkg::MODE_NORM, 4'd15, '0);
    endtask

    // mostly clear / collect / normalize runs on one feature, some raw noise
    task automatic test_random_traffic(input int n_items);
        int                          sent;
        int                          base;
        int                          spread;
        int                          n_col;
        int                          n_norm;
        logic [mmfn_pkg::IDX_W-1:0]  f;
        logic [mmfn_pkg::MODE_W-1:0] m;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 80) begin
                f      = mmfn_pkg::IDX_W'($urandom_range(0, mmfn_pkg::MAX_FEATURES - 1));
                base   = $signed($urandom) >>> 8;
                spread = 1 << $urandom_range(0, 23);
                if ($urandom_range(0, 99) < 85) begin
                    send_item(mmfn_pkg::MODE_CLEAR, f, mmfn_pkg::VAL_W'($urandom));
                    sent++;
                end
                n_col = $urandom_range(1, 6);
                repeat (n_col) begin
                    send_item(mmfn_pkg::MODE_COLLECT, f, near_value(base, spread));
                    sent++;
                end
                n_norm = $urandom_range(1, 6);
                repeat (n_norm) begin
                    // slightly wider than the collected spread to hit both clamps
                    send_item(mmfn_pkg::MODE_NORM, f, near_value(base, spread + spread / 4));
                    sent++;
                end
            end else begin
                m = mmfn_pkg::MODE_W'($urandom_range(0, 3));
                send_item(m, mmfn_pkg::IDX_W'($urandom), mmfn_pkg::VAL_W'($urandom));
                if (m != MODE_UNUSED) sent++;
            end
        end
    endtask

    // master side: random tready and result checking against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_norm.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual %0d %0d %0d",
                         $time, o_m_tdata[16:0], o_m_tuser, o_m_tdata[20:17]);
                mismatch_count++;
            end else begin
                want_result = pending_norm.pop_front();
                if (o_m_tdata[16:0] !== want_result.scaled) begin
                    $display("%0t: scaled_value expected %0d actual %0d",
                             $time, want_result.scaled, o_m_tdata[16:0]);
                    mismatch_count++;
                end
                if (o_m_tuser !== want_result.degen) begin
                    $display("%0t: degenerate expected %0d actual %0d",
                             $time, want_result.degen, o_m_tuser);
                    mismatch_count++;
                end
                if (o_m_tdata[20:17] !== want_result.feat) begin
                    $display("%0t: result_feature expected %0d actual %0d",
                             $time, want_result.feat, o_m_tdata[20:17]);
                    mismatch_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // test sequence
    initial begin
        for (int i = 0; i < mmfn_pkg::MAX_FEATURES; i++) begin
            feat_max[i] = mmfn_pkg::VAL_MOST_NEG;
            feat_min[i] = mmfn_pkg::VAL_MOST_POS;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // slow sender, heavily stalled receiver
        src_idle_pct   = 27;
        sink_stall_pct = 85;
        test_empty_features();
        test_zero_range();
        test_full_range_extremes();
        test_unused_mode_and_clear();
        test_clamping();
        test_random_traffic(480);

        // bursty sender, mostly ready receiver
        src_idle_pct   = 85;
        sink_stall_pct = 27;
        test_random_traffic(480);

        // back to back on both sides
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_traffic(470);

        i_s_tvalid <= 1'b0;
        while (pending_norm.size() != 0) @(posedge i_clk);
        // let a trailing collect or clear finish before ending
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog, well past the slowest legal run
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/mmfn_pkg.sv
hw/rtl/mmfn_div.sv
hw/rtl/min_max_feature_normalizer.sv
tb/tb_min_max_feature_normalizer.sv
